// ===== rtl/polygon_face_normal_macros.svh =====
// Assertion macros shared by the polygon face normal RTL
`ifndef POLYGON_FACE_NORMAL_MACROS_SVH
`define POLYGON_FACE_NORMAL_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset
`define PFN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked through reset
`define PFN_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfn_pkg.sv =====
// Types and constants for the polygon face normal block
package pfn_pkg;

    localparam int POS_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int PROD_W     = 50;
    localparam int SUM_W      = 60;
    localparam int MAG_W      = 30;
    localparam int L2_W       = 62;
    localparam int ROOT_W     = 63;
    localparam int NORM_W     = 16;
    localparam int POLY_OUT_W = 20;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [NORM_W-1:0]       NORM_ONE = 16'd16384;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum_x;
        logic signed [SUM_W-1:0]  sum_y;
        logic signed [SUM_W-1:0]  sum_z;
        logic                     enough;
        logic [POLY_OUT_W-1:0]    poly;
    } t_poly_sum;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [PROD_W:0]   b
    );
        logic signed [SUM_W:0] s;
        s = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W-PROD_W){b[PROD_W]}}, b});
        if (s > $signed({SUM_MAX[SUM_W-1], SUM_MAX}))
            return SUM_MAX;
        else if (s < $signed({SUM_MIN[SUM_W-1], SUM_MIN}))
            return SUM_MIN;
        else
            return s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/pfn_front.sv =====
// Corner intake: fan cross products on a shared multiplier, saturating sum
module pfn_front import pfn_pkg::*; #(
    parameter int MAX_CORNERS     = 256,
    parameter int POLY_INDEX_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tvalid,
    output logic                    o_tready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_last,
    output logic                    o_push,
    input  logic                    i_q_ready,
    output t_poly_sum               o_entry
);

    localparam int CNT_W = $clog2(MAX_CORNERS + 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} t_state;

    t_state                     r_state;
    logic [2:0]                 r_step;
    logic signed [POS_W-1:0]    r_first [3];
    logic signed [POS_W-1:0]    r_prev  [3];
    logic signed [DIFF_W-1:0]   r_a     [3];
    logic signed [DIFF_W-1:0]   r_b     [3];
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_lhs;
    logic signed [SUM_W-1:0]    r_sum   [3];
    logic [CNT_W-1:0]           r_cnt;
    logic [POLY_INDEX_BITS-1:0] r_poly;
    logic                       r_last;

    logic                       w_acc;
    logic signed [POS_W-1:0]    w_v [3];
    logic signed [POS_W-1:0]    w_f [3];
    logic signed [POS_W-1:0]    w_p [3];
    logic signed [DIFF_W-1:0]   w_op_a, w_op_b;
    logic signed [PROD_W-1:0]   w_mul;
    logic signed [PROD_W:0]     w_cross;
    logic [1:0]                 w_sidx;
    logic [POLY_INDEX_BITS+POLY_OUT_W-1:0] w_poly_ext;

    assign w_v[0] = i_pos_x;
    assign w_v[1] = i_pos_y;
    assign w_v[2] = i_pos_z;

    assign o_tready = (r_state == S_IDLE);
    assign w_acc    = i_tvalid && o_tready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_f[i] = (r_cnt == '0) ? w_v[i] : r_first[i];
            w_p[i] = (r_cnt == '0) ? w_v[i] : r_prev[i];
        end
    end

    always_comb begin
        unique case (r_step)
            3'd0:    begin w_op_a = r_a[1]; w_op_b = r_b[2]; end
            3'd1:    begin w_op_a = r_a[2]; w_op_b = r_b[1]; end
            3'd2:    begin w_op_a = r_a[2]; w_op_b = r_b[0]; end
            3'd3:    begin w_op_a = r_a[0]; w_op_b = r_b[2]; end
            3'd4:    begin w_op_a = r_a[0]; w_op_b = r_b[1]; end
            3'd5:    begin w_op_a = r_a[1]; w_op_b = r_b[0]; end
            default: begin w_op_a = r_a[0]; w_op_b = r_b[0]; end
        endcase
    end

    assign w_mul   = w_op_a * w_op_b;
    assign w_cross = $signed({r_lhs[PROD_W-1], r_lhs}) - $signed({r_prod[PROD_W-1], r_prod});
    assign w_sidx  = r_step[2:1] - 2'd1;

    assign w_poly_ext = {{POLY_OUT_W{1'b0}}, r_poly};

    assign o_push         = (r_state == S_PUSH) && i_q_ready;
    assign o_entry.sum_x  = r_sum[0];
    assign o_entry.sum_y  = r_sum[1];
    assign o_entry.sum_z  = r_sum[2];
    assign o_entry.enough = (r_cnt >= CNT_W'(3));
    assign o_entry.poly   = w_poly_ext[POLY_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_poly  <= '0;
            r_last  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i]   <= '0;
                r_first[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        for (int i = 0; i < 3; i++) begin
                            r_a[i]     <= $signed({w_p[i][POS_W-1], w_p[i]})
                                        - $signed({w_f[i][POS_W-1], w_f[i]});
                            r_b[i]     <= $signed({w_v[i][POS_W-1], w_v[i]})
                                        - $signed({w_f[i][POS_W-1], w_f[i]});
                            r_first[i] <= w_f[i];
                            r_prev[i]  <= w_v[i];
                        end
                        if (r_cnt < CNT_W'(MAX_CORNERS))
                            r_cnt <= r_cnt + CNT_W'(1);
                        r_last  <= i_last;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_mul;
                    // odd step: first term of a component arrives; even step: finish it
                    if (r_step[0])
                        r_lhs <= r_prod;
                    else if (r_step != 3'd0)
                        r_sum[w_sidx] <= sat_add(r_sum[w_sidx], w_cross);
                    if (r_step == 3'd6) begin
                        r_state <= r_last ? S_PUSH : S_IDLE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_PUSH: begin
                    if (i_q_ready) begin
                        for (int i = 0; i < 3; i++)
                            r_sum[i] <= '0;
                        r_cnt   <= '0;
                        r_poly  <= r_poly + POLY_INDEX_BITS'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/pfn_queue.sv =====
// Two-entry queue of finished polygon sums between intake and normalizer
module pfn_queue import pfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_poly_sum i_entry,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_poly_sum o_entry
);

    t_poly_sum  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_entry;
                r_wp        <= ~r_wp;
            end
            if (i_pop)
                r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/pfn_back.sv =====
// Normalizer: shift, squared length, bitwise root, long division per component
module pfn_back import pfn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_pop,
    input  t_poly_sum                i_entry,
    output logic                     o_tvalid,
    input  logic                     i_tready,
    output logic signed [NORM_W-1:0] o_norm_x,
    output logic signed [NORM_W-1:0] o_norm_y,
    output logic signed [NORM_W-1:0] o_norm_z,
    output logic [POLY_OUT_W-1:0]    o_poly,
    output logic                     o_degenerate
);

    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQUARE, S_ROOT, S_DIVIDE, S_OUT} t_state;

    t_state                    r_state;
    logic [SUM_W-1:0]          r_mag [3];
    logic [SUM_W-1:0]          r_max;
    logic                      r_neg [3];
    logic                      r_deg;
    logic [POLY_OUT_W-1:0]     r_poly;
    logic [1:0]                r_idx;
    logic [2*MAG_W-1:0]        r_sq;
    logic [L2_W-1:0]           r_l2;
    logic [L2_W-1:0]           r_x;
    logic [ROOT_W-1:0]         r_res;
    logic [ROOT_W-1:0]         r_bit;
    logic [30:0]               r_rem;
    logic [NORM_W-1:0]         r_num;
    logic [NORM_W-1:0]         r_q;
    logic [4:0]                r_dcnt;
    logic signed [NORM_W-1:0]  r_norm [3];
    logic                      r_ov;
    logic signed [NORM_W-1:0]  r_onx, r_ony, r_onz;
    logic [POLY_OUT_W-1:0]     r_opoly;
    logic                      r_odeg;

    logic signed [SUM_W-1:0]   w_sum [3];
    logic [SUM_W-1:0]          w_mag [3];
    logic [SUM_W-1:0]          w_m01, w_max;
    logic [ROOT_W:0]           w_trial;
    logic                      w_take;
    logic [30:0]               w_r;
    logic [44:0]               w_num;
    logic [31:0]               w_t;
    logic                      w_ge;
    logic [NORM_W-1:0]         w_qn, w_qc;
    logic                      w_ofree;

    assign w_sum[0] = i_entry.sum_x;
    assign w_sum[1] = i_entry.sum_y;
    assign w_sum[2] = i_entry.sum_z;

    always_comb begin
        for (int i = 0; i < 3; i++)
            w_mag[i] = w_sum[i][SUM_W-1] ? SUM_W'(-w_sum[i]) : w_sum[i];
    end
    assign w_m01 = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
    assign w_max = (w_m01 > w_mag[2]) ? w_m01 : w_mag[2];

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = ({2'b0, r_x} >= w_trial);

    assign w_r   = r_res[30:0];
    assign w_num = {1'b0, r_mag[r_idx][MAG_W-1:0], 14'b0} + {15'b0, w_r[30:1]};
    assign w_t   = {r_rem, r_num[NORM_W-1]};
    assign w_ge  = (w_t >= {1'b0, w_r});
    assign w_qn  = {r_q[NORM_W-2:0], w_ge};
    assign w_qc  = (w_qn > NORM_ONE) ? NORM_ONE : w_qn;

    assign w_ofree = !r_ov || i_tready;

    assign o_tvalid     = r_ov;
    assign o_norm_x     = r_onx;
    assign o_norm_y     = r_ony;
    assign o_norm_z     = r_onz;
    assign o_poly       = r_opoly;
    assign o_degenerate = r_odeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // drop the taken beat unless a new one replaces it
            if (r_ov && i_tready && (r_state != S_OUT))
                r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i]  <= w_mag[i];
                            r_neg[i]  <= w_sum[i][SUM_W-1];
                            r_norm[i] <= '0;
                        end
                        r_max   <= w_max;
                        r_poly  <= i_entry.poly;
                        r_deg   <= !i_entry.enough || (w_max == '0);
                        r_state <= (!i_entry.enough || (w_max == '0)) ? S_OUT : S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_max[SUM_W-1:MAG_W] != '0) begin
                        for (int i = 0; i < 3; i++)
                            r_mag[i] <= r_mag[i] >> 1;
                        r_max <= r_max >> 1;
                    end else begin
                        r_idx   <= '0;
                        r_l2    <= '0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_sq <= r_mag[r_idx][MAG_W-1:0] * r_mag[r_idx][MAG_W-1:0];
                    if (r_idx != 2'd0)
                        r_l2 <= r_l2 + L2_W'(r_sq);
                    if (r_idx == 2'd3) begin
                        r_x     <= r_l2 + L2_W'(r_sq);
                        r_res   <= '0;
                        r_bit   <= {1'b1, {(ROOT_W-1){1'b0}}};
                        r_state <= S_ROOT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        r_idx  <= '0;
                        r_dcnt <= '0;
                        if (r_res == '0) begin
                            r_deg   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIVIDE;
                        end
                    end else begin
                        if (w_take) begin
                            r_x   <= r_x - L2_W'(w_trial);
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIVIDE: begin
                    if (r_dcnt == '0) begin
                        r_rem  <= {2'b0, w_num[44:16]};
                        r_num  <= w_num[15:0];
                        r_q    <= '0;
                        r_dcnt <= 5'd1;
                    end else begin
                        r_rem <= w_ge ? 31'(w_t - {1'b0, w_r}) : w_t[30:0];
                        r_num <= r_num << 1;
                        r_q   <= w_qn;
                        if (r_dcnt == 5'd16) begin
                            r_norm[r_idx] <= r_neg[r_idx] ? -$signed(w_qc) : $signed(w_qc);
                            r_dcnt        <= '0;
                            if (r_idx == 2'd2)
                                r_state <= S_OUT;
                            else
                                r_idx <= r_idx + 2'd1;
                        end else begin
                            r_dcnt <= r_dcnt + 5'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_ofree) begin
                        r_ov    <= 1'b1;
                        r_onx   <= r_deg ? '0 : r_norm[0];
                        r_ony   <= r_deg ? '0 : r_norm[1];
                        r_onz   <= r_deg ? '0 : r_norm[2];
                        r_opoly <= r_poly;
                        r_odeg  <= r_deg;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/polygon_face_normal.sv =====
// Top level of the streamed polygon face normal block
//
//  channel   | direction | beat carries
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one polygon corner; tlast marks the final corner
//  m_axis    | out       | one unit normal per polygon; tuser flags degenerate
//
// Intake: each corner is a beat taken, then six fan products on one shared 25x25
// multiplier folded into the sum; the final corner then waits to hand the sum on.
// Normalizer, per polygon: load, shifts until the largest magnitude fits 30 bits and a
// finishing step, squaring, root and division steps, emit; a degenerate polygon goes from load to emit.
// A stalled m_axis holds the normalizer; a full two-entry queue holds the intake.
// Reset is synchronous; the intake sums and counts, the queue count and the polygon index clear to zero.
`include "polygon_face_normal_macros.svh"
module polygon_face_normal import pfn_pkg::*; #(
    parameter int MAX_CORNERS     = 256,
    parameter int POLY_INDEX_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // pos_x[23:0], pos_y[47:24], pos_z[71:48]
    input  logic        i_s_axis_tlast,  // last_corner
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // norm_x, norm_y, norm_z, poly_number, zero pad
    output logic        o_m_axis_tuser   // degenerate
);

    logic                     w_push, w_q_ready, w_q_valid, w_pop;
    t_poly_sum                w_front_entry, w_back_entry;
    logic signed [NORM_W-1:0] w_nx, w_ny, w_nz;
    logic [POLY_OUT_W-1:0]    w_poly;

    pfn_front #(
        .MAX_CORNERS     (MAX_CORNERS),
        .POLY_INDEX_BITS (POLY_INDEX_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_pos_x   (i_s_axis_tdata[23:0]),
        .i_pos_y   (i_s_axis_tdata[47:24]),
        .i_pos_z   (i_s_axis_tdata[71:48]),
        .i_last    (i_s_axis_tlast),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_entry   (w_front_entry)
    );

    pfn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_back_entry)
    );

    pfn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_pop),
        .i_entry      (w_back_entry),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_norm_x     (w_nx),
        .o_norm_y     (w_ny),
        .o_norm_z     (w_nz),
        .o_poly       (w_poly),
        .o_degenerate (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0, w_poly, w_nz, w_ny, w_nx};

    `PFN_ASSERT_SAME(a_degen_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[47:0] == 48'd0, "degenerate beat carries a nonzero normal")
    `PFN_ASSERT_SAME(a_push_room, i_clk, i_rst_n, w_push, w_q_ready, "polygon sum pushed into a full queue")
    `PFN_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_m_axis_tvalid && !w_q_valid, "output or queue not empty after reset")

endmodule
